[rtl/assert_macros.svh]
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition now implies consequence in the next cycle
`define SHAE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("shae check failed");

// condition implies consequence in the same cycle
`define SHAE_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shae check failed");

`endif

[rtl/shae_pkg.sv]
package shae_pkg;

  // config register indexes
  localparam logic CFG_PAD_MODE = 1'b0;
  localparam logic CFG_DOUBLE   = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef struct packed {
    logic load;     // copy chain value into working vars
    logic step;     // run one round
    logic add;      // fold working vars into chain value
    logic save;     // copy chain value into digest hold
    logic restart;  // chain value back to initial value
  } round_ctl_t;

  localparam logic [31:0] IV_TAB [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

endpackage

[rtl/shae_wmem.sv]
module shae_wmem (
  input  logic        clk,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic        rd_en,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data
);

  // block word store, one write and one registered read port
  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/shae_round.sv]
module shae_round (
  input  logic                clk,
  input  logic                rst,
  input  shae_pkg::round_ctl_t ctl,
  input  logic [5:0]          rnd,
  input  logic [31:0]         w_mem,
  input  logic [2:0]          sel,
  output logic [31:0]         chain_word,
  output logic [31:0]         dig_word
);

  import shae_pkg::*;

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  logic [31:0] chain [8];
  logic [31:0] dig   [8];
  logic [31:0] v     [8];
  logic [31:0] win   [16];  // win[0] is the oldest schedule word
  logic [31:0] wt, t1, t2, ch, maj;

  always_comb begin
    wt  = (rnd[5:4] == 2'b00) ? w_mem
        : ssig1(win[14]) + win[9] + ssig0(win[1]) + win[0];
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t1  = v[7] + bsig1(v[4]) + ch + K_TAB[rnd] + wt;
    t2  = bsig0(v[0]) + maj;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      for (int i = 0; i < 8; i++) chain[i] <= IV_TAB[i];
    end else if (ctl.add) begin
      for (int i = 0; i < 8; i++) chain[i] <= chain[i] + v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.save) begin
      for (int i = 0; i < 8; i++) dig[i] <= chain[i];
    end
    if (ctl.load) begin
      for (int i = 0; i < 8; i++) v[i] <= chain[i];
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
    if (ctl.step) begin
      for (int i = 0; i < 15; i++) win[i] <= win[i+1];
      win[15] <= wt;
    end
  end

  assign chain_word = chain[sel];
  assign dig_word   = dig[sel];

endmodule

[rtl/sha256_hash_engine.sv]
// channel   dir  handshake               payload
// cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
// message   in   in_valid / in_ready     msg_byte, msg_last
// digest    out  out_valid / out_ready   digest_word, word_last, length_error
//
// message bytes are taken one per cycle while in_ready is high; each full 64-byte block is then
// compressed (read prime, 64 rounds at one round per cycle, chain add)
// padding and zero fill run one byte per cycle through the same packer, pausing while a block compresses
// double hash adds 32 digest bytes, 32 pad bytes and one more block
// rst is synchronous: chain value to initial value, counters and modes cleared
// input stalls while a block compresses and while the 8 digest words drain
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  msg_byte,
  input  logic        msg_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic        word_last,
  output logic        length_error
);

  import shae_pkg::*;

  // sequencer states
  typedef enum logic [7:0] {
    ST_IN   = 8'b0000_0001,  // taking message bytes
    ST_PAD  = 8'b0000_0010,  // padding or zero fill
    ST_DBL  = 8'b0000_0100,  // feeding first digest back in
    ST_LOAD = 8'b0000_1000,  // prime the word read, load working vars
    ST_COMP = 8'b0001_0000,  // 64 rounds
    ST_ADD  = 8'b0010_0000,  // fold into chain value
    ST_FIN  = 8'b0100_0000,  // message done, choose second pass or output
    ST_OUT  = 8'b1000_0000   // drain digest words
  } state_t;

  state_t      state, state_next;

  // config registers
  logic        pad_mode, double_hash;

  // message bookkeeping
  logic [5:0]  fill;        // bytes held in the current block
  logic [23:0] acc;         // bytes of the word being packed
  logic [63:0] bit_count;
  logic [63:0] len;         // length field for the padding
  logic        sent80;
  logic [3:0]  len_cnt;     // length bytes sent
  logic        ending;      // finishing a message, compress returns to padding
  logic        mode_raw, mode_dbl, second, err;
  logic [4:0]  didx;        // digest byte being fed back
  logic [5:0]  rnd;
  logic [2:0]  oidx;

  // byte packer
  logic        put_en;
  logic [7:0]  put_byte;

  // memory and round unit
  logic        wr_en, rd_en;
  logic [3:0]  rd_addr;
  logic [31:0] rd_data;
  logic [31:0] chain_word, dig_word;
  logic [2:0]  sel;
  round_ctl_t  ctl;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IN);
  assign out_valid = (state == ST_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pad_mode    <= 1'b0;
      double_hash <= 1'b0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_PAD_MODE) pad_mode <= cfg_data;
      if (cfg_index == CFG_DOUBLE)   double_hash <= cfg_data;
    end
  end

  // byte source selection
  always_comb begin
    put_en   = 1'b0;
    put_byte = '0;
    unique case (state)
      ST_IN: begin
        put_en   = in_valid;
        put_byte = msg_byte;
      end
      ST_PAD: begin
        if (mode_raw) begin
          put_en = (fill != 6'd0);
        end else if (len_cnt != 4'd8) begin
          put_en = 1'b1;
          if (!sent80) put_byte = PAD_BYTE;
          else if (len_cnt == 4'd0 && fill != 6'd56) put_byte = '0;
          else put_byte = len[{~len_cnt[2:0], 3'b000} +: 8];
        end
      end
      ST_DBL: begin
        put_en   = 1'b1;
        put_byte = dig_word[{~didx[1:0], 3'b000} +: 8];
      end
      default: begin
        put_en   = 1'b0;
        put_byte = '0;
      end
    endcase
  end

  // a word is written once its fourth byte arrives; the store is only read
  // while loading and during compression, so reads and writes never overlap
  assign wr_en   = put_en && (fill[1:0] == 2'b11);
  assign rd_en   = (state == ST_LOAD) || (state == ST_COMP);
  assign rd_addr = (state == ST_COMP) ? rnd[3:0] + 4'd1 : 4'd0;
  assign sel     = (state == ST_DBL) ? didx[4:2] : oidx;

  always_comb begin
    ctl         = '0;
    ctl.load    = (state == ST_LOAD);
    ctl.step    = (state == ST_COMP);
    ctl.add     = (state == ST_ADD);
    ctl.save    = (state == ST_FIN) && mode_dbl && !second;
    ctl.restart = ctl.save || (out_valid && out_ready && oidx == 3'd7);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IN: begin
        if (in_valid) begin
          if (fill == 6'd63) state_next = ST_LOAD;
          else if (msg_last) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        if (!put_en) state_next = ST_FIN;
        else if (fill == 6'd63) state_next = ST_LOAD;
      end
      ST_DBL: begin
        if (didx == 5'd31) state_next = ST_PAD;
      end
      ST_LOAD: state_next = ST_COMP;
      ST_COMP: begin
        if (rnd == 6'd63) state_next = ST_ADD;
      end
      ST_ADD:  state_next = ending ? ST_PAD : ST_IN;
      ST_FIN:  state_next = (mode_dbl && !second) ? ST_DBL : ST_OUT;
      ST_OUT: begin
        if (out_ready && oidx == 3'd7) state_next = ST_IN;
      end
      default: state_next = ST_IN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IN;
      fill      <= '0;
      bit_count <= '0;
      ending    <= 1'b0;
      second    <= 1'b0;
      sent80    <= 1'b0;
      len_cnt   <= '0;
      mode_raw  <= 1'b0;
      mode_dbl  <= 1'b0;
      err       <= 1'b0;
      didx      <= '0;
      rnd       <= '0;
      oidx      <= '0;
    end else begin
      state <= state_next;
      if (put_en) begin
        fill <= fill + 6'd1;
      end
      // length bytes counted once the 0x80 marker and zeros are out
      if (state == ST_PAD && put_en && !mode_raw) begin
        if (!sent80) sent80 <= 1'b1;
        else if (len_cnt != 4'd0 || fill == 6'd56) len_cnt <= len_cnt + 4'd1;
      end
      if (state == ST_IN && in_valid) begin
        bit_count <= bit_count + 64'd8;
        if (msg_last) begin
          ending   <= 1'b1;
          mode_raw <= pad_mode;
          mode_dbl <= double_hash;
          sent80   <= 1'b0;
          len_cnt  <= '0;
          err      <= pad_mode && (fill != 6'd63);
        end
      end
      if (state == ST_LOAD) rnd <= '0;
      if (state == ST_COMP) rnd <= rnd + 6'd1;
      if (state == ST_FIN && mode_dbl && !second) begin
        second <= 1'b1;
        didx   <= '0;
      end
      if (state == ST_DBL) begin
        didx <= didx + 5'd1;
        if (didx == 5'd31) begin
          // second pass always pads a 256-bit message
          mode_raw <= 1'b0;
          sent80   <= 1'b0;
          len_cnt  <= '0;
        end
      end
      if (state == ST_FIN) oidx <= '0;
      if (out_valid && out_ready) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          bit_count <= '0;
          second    <= 1'b0;
          ending    <= 1'b0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (put_en) acc <= {acc[15:0], put_byte};
    if (state == ST_IN && in_valid && msg_last) len <= bit_count + 64'd8;
    if (state == ST_DBL && didx == 5'd31) len <= 64'd256;
  end

  shae_wmem u_wmem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill[5:2]),
    .wr_data ({acc, put_byte}),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  shae_round u_round (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .rnd        (rnd),
    .w_mem      (rd_data),
    .sel        (sel),
    .chain_word (chain_word),
    .dig_word   (dig_word)
  );

  assign digest_word  = chain_word;
  assign word_last    = (oidx == 3'd7);
  assign length_error = err;

endmodule

[rtl/shae_checker.sv]
module shae_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] digest_word,
  input logic        word_last,
  input logic        length_error
);

  `include "assert_macros.svh"

  // input is never taken while digest words drain
  `SHAE_ASSERT_NOW(a_no_overlap, out_valid, !in_ready)
  // last digest word ends the output burst
  `SHAE_ASSERT_NEXT(a_last_ends, out_valid && out_ready && word_last, !out_valid)
  // error flag is the same on every word of one digest
  `SHAE_ASSERT_NEXT(a_err_steady, out_valid && out_ready && !word_last,
                    out_valid && length_error == $past(length_error))
  // stalled digest word holds
  `SHAE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(digest_word))

endmodule

bind sha256_hash_engine shae_checker u_shae_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .digest_word  (digest_word),
  .word_last    (word_last),
  .length_error (length_error)
);

[sim/sha256_hash_engine_tb.sv]
`timescale 1ns / 1ps

module sha256_hash_engine_tb;
  import shae_pkg::*;

  // one message byte as offered on the input channel
  typedef struct {
    logic [7:0] data;
    logic       last;
  } msg_item_t;

  // one digest word as expected on the output channel
  typedef struct {
    logic [31:0] word;
    logic        last;
    logic        err;
  } digest_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_PAD_MODE;
  logic        cfg_data = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  msg_byte = 8'h00;
  logic        msg_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic        word_last;
  logic        length_error;

  sha256_hash_engine DUT (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .msg_byte(msg_byte), .msg_last(msg_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .digest_word(digest_word), .word_last(word_last),
    .length_error(length_error)
  );

  always #5 clk = ~clk;

  // shadow state of the hash engine
  logic [31:0] chain_q [8];
  logic [31:0] blk_q [16];
  logic [63:0] bits_q;
  logic [5:0]  fill_q;
  logic        raw_mode_q;
  logic        dbl_mode_q;

  msg_item_t    msg_queue [$];
  digest_item_t digest_queue [$];

  int  errors = 0;
  bit  send_paused = 1'b0;   // sender holds off while this is set
  bit  hold_rx = 1'b0;       // request a long receiver stall
  bit  calm = 1'b0;          // no more random idling
  int  idle_cycles = 0;

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // one 64-round compression of blk_q into chain_q
  function automatic void sha_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    int r;
    w = blk_q;
    v = chain_q;
    for (int t = 0; t < 64; t++) begin
      r = t & 15;
      if (t >= 16) begin
        s0 = ror(w[(r+1)&15], 7) ^ ror(w[(r+1)&15], 18) ^ (w[(r+1)&15] >> 3);
        s1 = ror(w[(r+14)&15], 17) ^ ror(w[(r+14)&15], 19) ^ (w[(r+14)&15] >> 10);
        w[r] = w[r] + s0 + w[(r+9)&15] + s1;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + w[r];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_q[i] = chain_q[i] + v[i];
  endfunction

  // pack one byte big-endian, compress on a full block
  function automatic void pack_byte(logic [7:0] b);
    int wi;
    wi = fill_q >> 2;
    if (fill_q[1:0] == 2'd0) blk_q[wi] = '0;
    blk_q[wi][8*(3-fill_q[1:0]) +: 8] = b;
    fill_q = fill_q + 6'd1;
    if (fill_q == 6'd0) sha_block();
  endfunction

  function automatic void hash_restart();
    for (int i = 0; i < 8; i++) chain_q[i] = IV_TAB[i];
    bits_q = '0;
    fill_q = '0;
  endfunction

  // digest predictor: queues eight words when a message ends
  function automatic void hash_accept(msg_item_t m);
    logic [63:0] len;
    logic        err;
    digest_item_t d;
    err = 1'b0;
    bits_q = bits_q + 64'd8;
    pack_byte(m.data);
    if (!m.last) return;
    if (!raw_mode_q) begin
      len = bits_q;
      pack_byte(PAD_BYTE);
      while (fill_q != 6'd56) pack_byte(8'h00);
      for (int i = 0; i < 8; i++) pack_byte(len[8*(7-i) +: 8]);
    end else if (fill_q != 6'd0) begin
      // raw message ended mid block: zero fill and flag it
      err = 1'b1;
      while (fill_q != 6'd0) pack_byte(8'h00);
    end
    if (dbl_mode_q) begin
      // second pass over the 32-byte digest, always standard padding
      for (int i = 0; i < 8; i++) blk_q[i] = chain_q[i];
      blk_q[8] = 32'h8000_0000;
      for (int i = 9; i < 15; i++) blk_q[i] = '0;
      blk_q[15] = 32'd256;
      for (int i = 0; i < 8; i++) chain_q[i] = IV_TAB[i];
      sha_block();
    end
    for (int i = 0; i < 8; i++) begin
      d.word = chain_q[i];
      d.last = (i == 7);
      d.err  = err;
      digest_queue.push_back(d);
    end
    hash_restart();
  endfunction

  // input accepted at the latest rising edge
  bit tx_acc = 1'b0;
  always @(posedge clk) begin
    tx_acc <= in_valid && in_ready;
  end

  // ---------------------------------------------------------------
  // driver: message bytes from msg_queue, random idle bursts
  // ---------------------------------------------------------------
  int tx_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !tx_acc) begin
        // hold the offered item
      end else if (tx_gap > 0) begin
        tx_gap <= tx_gap - 1;
        in_valid <= 1'b0;
      end else if (!send_paused && msg_queue.size() > 0 &&
                   !(in_valid && msg_last)) begin
        // after a last byte always drop in_valid before the next is offered,
        // the previous accept has been consumed at the preceding posedge
        msg_byte <= msg_queue[0].data;
        msg_last <= msg_queue[0].last;
        in_valid <= 1'b1;
        void'(msg_queue.pop_front());
        if (!calm && $urandom_range(0, 9) == 0) tx_gap <= $urandom_range(1, 16);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stall bursts, one long hold on request
  int rx_gap = 0;
  int rx_hold = 0;
  bit rx_done = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_rx && !rx_done && rx_hold == 0) begin
        rx_hold <= 400;
        rx_done <= 1'b1;
        out_ready <= 1'b0;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_ready <= (rx_hold == 1);
      end else if (rx_gap > 0) begin
        rx_gap <= rx_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!calm && $urandom_range(0, 7) == 0) rx_gap <= $urandom_range(1, 16);
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: predict on accepted bytes, check accepted digest words
  // ---------------------------------------------------------------
  msg_item_t    seen;
  digest_item_t exp_d;
  bit           busy;
  always @(posedge clk) begin
    if (!rst) begin
      busy = 1'b0;
      if (in_valid && in_ready) begin
        seen.data = msg_byte;
        seen.last = msg_last;
        hash_accept(seen);
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) busy = 1'b1;
      if (out_valid && out_ready) begin
        busy = 1'b1;
        if (digest_queue.size() == 0) begin
          $display("%0t: unexpected digest word %h", $time, digest_word);
          errors++;
        end else begin
          exp_d = digest_queue.pop_front();
          if (digest_word !== exp_d.word || word_last !== exp_d.last ||
              length_error !== exp_d.err) begin
            $display("%0t: digest mismatch expected %h/%b/%b actual %h/%b/%b", $time,
                     exp_d.word, exp_d.last, exp_d.err,
                     digest_word, word_last, length_error);
            errors++;
          end
        end
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // register write while the engine is idle
  task automatic write_reg(logic idx, logic val);
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_PAD_MODE) raw_mode_q = val;
    else dbl_mode_q = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // wait for the input queue and all digest words to drain
  task automatic drain();
    while (msg_queue.size() > 0 || in_valid || digest_queue.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic add_msg(int len, bit rand_data);
    msg_item_t m;
    for (int i = 0; i < len; i++) begin
      m.data = rand_data ? 8'($urandom_range(0, 255)) : 8'(i * 37 + 1);
      m.last = (i == len - 1);
      msg_queue.push_back(m);
    end
  endtask

  // pick a short message length
  function automatic int msg_len(bit raw);
    if (raw) return $urandom_range(1, 6);
    return $urandom_range(1, 4);
  endfunction

  int sent;
  initial begin
    raw_mode_q = 1'b0;
    dbl_mode_q = 1'b0;
    hash_restart();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: single bytes at extremes, then a short message
    msg_queue.push_back('{8'h00, 1'b1});
    msg_queue.push_back('{8'hFF, 1'b1});
    add_msg(3, 1'b0);
    drain();
    // sender paused while a nine-byte message is queued, then released
    send_paused = 1'b1;
    add_msg(9, 1'b1);
    repeat (20) @(posedge clk);
    send_paused = 1'b0;
    drain();

    // raw mode: one full block and a short block that must flag
    write_reg(CFG_PAD_MODE, 1'b1);
    add_msg(64, 1'b1);
    add_msg(5, 1'b1);
    drain();

    // raw plus double hash, then pad plus double hash
    write_reg(CFG_DOUBLE, 1'b1);
    add_msg(3, 1'b1);
    drain();
    write_reg(CFG_PAD_MODE, 1'b0);
    add_msg(6, 1'b1);
    // long receiver stall while bytes keep coming
    hold_rx = 1'b1;
    add_msg(4, 1'b1);
    drain();

    // random phases over every register setting
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_PAD_MODE, ph[0]);
      write_reg(CFG_DOUBLE, ph[1]);
      sent = 0;
      while (sent < 4) begin
        automatic int n = msg_len(ph[0]);
        add_msg(n, 1'b1);
        sent += n;
      end
      if (ph == 3) calm = 1'b1;
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
